// ===== rtl/core/wps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wps_pkg: shared types and constants for the waypoint pursuit steering block
// CORDIC arctangent table, fixed-point constants and register indexes.
// ----------------------------------------------------------------------------
package wps_pkg;

   localparam int CordicStages = 16;
   localparam int TableLen     = 24;
   localparam int NumStages    = (CordicStages > TableLen) ? TableLen : CordicStages;

   // vectoring datapath width: 17-bit difference times 256, plus CORDIC growth
   localparam int VW = 29;
   // rotation datapath width (Q30 values with growth)
   localparam int RW = 33;

   localparam logic [29:0] InvGainQ30 = 30'd652032874;
   localparam logic [30:0] PiQ29      = 31'd1686629713;

   localparam logic [1:0] CSR_LOOKAHEAD = 2'd0;
   localparam logic [1:0] CSR_MAX_LIN   = 2'd1;
   localparam logic [1:0] CSR_TURN_GAIN = 2'd2;
   localparam logic [1:0] CSR_MAX_ANG   = 2'd3;

   typedef struct packed {
      logic [12:0] reach_radius;
      logic [14:0] max_linear_speed;
      logic [11:0] turn_gain;
      logic [14:0] max_angular_rate;
   } cfg_type;

   function automatic logic [31:0] atan_bam(input int i);
      logic [31:0] t;
      case (i)
         0: t = 32'd536870912;   1: t = 32'd316933406;  2: t = 32'd167458907;
         3: t = 32'd85004756;    4: t = 32'd42667331;   5: t = 32'd21354465;
         6: t = 32'd10679838;    7: t = 32'd5340245;    8: t = 32'd2670163;
         9: t = 32'd1335086;     10: t = 32'd667544;    11: t = 32'd333772;
         12: t = 32'd166886;     13: t = 32'd83443;     14: t = 32'd41722;
         15: t = 32'd20861;      16: t = 32'd10430;     17: t = 32'd5215;
         18: t = 32'd2608;       19: t = 32'd1304;      20: t = 32'd652;
         21: t = 32'd326;        22: t = 32'd163;       23: t = 32'd81;
         default: t = 32'd0;
      endcase
      return t;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/wps_vector.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wps_vector: pipelined CORDIC vectoring
// One micro-rotation per register stage; returns angle and raw magnitude.
// ----------------------------------------------------------------------------
module wps_vector (
   input  wire                         clock,
   input  wire signed [wps_pkg::VW-1:0] vec_x,
   input  wire signed [wps_pkg::VW-1:0] vec_y,
   output logic signed [wps_pkg::VW-1:0] mag,
   output logic [31:0]                  angle
);
   import wps_pkg::*;

   logic signed [VW-1:0] x_ff [NumStages+1];
   logic signed [VW-1:0] y_ff [NumStages+1];
   logic [31:0]          z_ff [NumStages+1];
   logic                 zero_ff [NumStages+1];

   // pre-rotate into the right half plane
   always_ff @(posedge clock) begin
      zero_ff[0] <= (vec_x == '0) && (vec_y == '0);
      if (vec_x < 0) begin
         x_ff[0] <= -vec_x;
         y_ff[0] <= -vec_y;
         z_ff[0] <= 32'h8000_0000;
      end else begin
         x_ff[0] <= vec_x;
         y_ff[0] <= vec_y;
         z_ff[0] <= '0;
      end
   end

   // micro-rotations, one per stage
   for (genvar i = 0; i < NumStages; i++) begin : g_stage
      always_ff @(posedge clock) begin
         zero_ff[i+1] <= zero_ff[i];
         if (y_ff[i] >= 0) begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + atan_bam(i);
         end else begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - atan_bam(i);
         end
      end
   end

   assign mag   = zero_ff[NumStages] ? '0 : x_ff[NumStages];
   assign angle = zero_ff[NumStages] ? '0 : z_ff[NumStages];

endmodule
`default_nettype wire

// ===== rtl/core/wps_cos.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wps_cos: pipelined CORDIC rotation for the cosine of the heading error
// Error limited to +-pi/2; outside that range the result is zero.
// ----------------------------------------------------------------------------
module wps_cos (
   input  wire         clock,
   input  wire  [15:0] err,
   output logic [14:0] cos14
);
   import wps_pkg::*;

   logic signed [RW-1:0] x_ff [NumStages+1];
   logic signed [RW-1:0] y_ff [NumStages+1];
   logic signed [RW-1:0] z_ff [NumStages+1];
   logic                 out_ff [NumStages+1];
   logic signed [RW-1:0] xr;

   // load 1/K and the angle
   always_ff @(posedge clock) begin
      x_ff[0]   <= RW'(InvGainQ30);
      y_ff[0]   <= '0;
      z_ff[0]   <= {{(RW-32){err[15]}}, err, 16'd0};
      out_ff[0] <= $signed(err) < -16'sd16384 || $signed(err) > 16'sd16384;
   end

   for (genvar i = 0; i < NumStages; i++) begin : g_stage
      always_ff @(posedge clock) begin
         out_ff[i+1] <= out_ff[i];
         if (z_ff[i] >= 0) begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - RW'(atan_bam(i));
         end else begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + RW'(atan_bam(i));
         end
      end
   end

   // round to Q1.14 and clamp
   always_comb begin
      xr = (x_ff[NumStages] + RW'(32768)) >>> 16;
      if (out_ff[NumStages] || x_ff[NumStages] <= 0) cos14 = '0;
      else if (xr > RW'(16384))                      cos14 = 15'd16384;
      else                                           cos14 = xr[14:0];
   end

endmodule
`default_nettype wire

// ===== rtl/core/waypoint_pursuit_steering.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// waypoint_pursuit_steering: pure pursuit steering toward one waypoint
// Path from start to rsp_valid: stage A, the vectoring CORDICs, stages B and C,
// the cosine CORDIC, then stages F and G. Throughput: one word per cycle, set by
// the fully pipelined CORDIC units; busy is always low and the receiver cannot stall.
// Reset restores register defaults and clears all valid bits.
// ----------------------------------------------------------------------------
module waypoint_pursuit_steering (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   output logic              busy,
   input  wire signed [15:0] req_pose_x,
   input  wire signed [15:0] req_pose_y,
   input  wire signed [15:0] req_quat_w,
   input  wire signed [15:0] req_quat_z,
   input  wire signed [15:0] req_target_x,
   input  wire signed [15:0] req_target_y,
   input  wire               req_final_waypoint,
   output logic              rsp_valid,
   output logic              rsp_advance,
   output logic [14:0]       rsp_linear_velocity,
   output logic signed [15:0] rsp_angular_velocity,
   input  wire               csr_write,
   input  wire  [1:0]        csr_index,
   input  wire  [14:0]       csr_data
);
   import wps_pkg::*;

   localparam int CL  = NumStages + 1;   // CORDIC latency
   localparam int LAT = 2 * CL + 4;

   cfg_type cfg_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reach_radius       <= 13'd512;
         cfg_ff.max_linear_speed   <= 15'd12288;
         cfg_ff.turn_gain          <= 12'd512;
         cfg_ff.max_angular_rate   <= 15'd16384;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_LOOKAHEAD: cfg_ff.reach_radius       <= csr_data[12:0];
            CSR_MAX_LIN:   cfg_ff.max_linear_speed   <= csr_data;
            CSR_TURN_GAIN: cfg_ff.turn_gain          <= csr_data[11:0];
            CSR_MAX_ANG:   cfg_ff.max_angular_rate   <= csr_data;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // valid bits travel along the whole pipe
   logic [LAT-1:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else       vld_ff <= {vld_ff[LAT-2:0], start};
   end

   // stage A: position difference and quaternion parts, scaled by 256
   logic signed [VW-1:0] dx_ff, dy_ff, qw_ff, qz_ff;
   logic                 fin_a_ff;
   always_ff @(posedge clock) begin
      dx_ff    <= VW'(req_target_x - req_pose_x) <<< 8;
      dy_ff    <= VW'(req_target_y - req_pose_y) <<< 8;
      qw_ff    <= VW'(req_quat_w) <<< 8;
      qz_ff    <= VW'(req_quat_z) <<< 8;
      fin_a_ff <= req_final_waypoint;
   end

   logic signed [VW-1:0] bmag, ymag;
   logic [31:0]          bang, yang;

   wps_vector u_bearing (.clock(clock), .vec_x(dx_ff), .vec_y(dy_ff),
                         .mag(bmag), .angle(bang));
   wps_vector u_yaw (.clock(clock), .vec_x(qw_ff), .vec_y(qz_ff),
                     .mag(ymag), .angle(yang));

   // delay the final flag alongside the CORDIC
   logic fin_d_ff [CL];
   always_ff @(posedge clock) begin
      fin_d_ff[0] <= fin_a_ff;
      for (int i = 1; i < CL; i++) fin_d_ff[i] <= fin_d_ff[i-1];
   end

   // stage B: magnitude times 1/K, angle error
   logic [59:0] dprod_ff;
   logic [15:0] err_b_ff;
   logic        fin_b_ff;
   logic [31:0] yaw2;
   logic [15:0] yaw16, bear16;
   always_comb begin
      yaw2   = yang << 1;
      yaw16  = 16'((yaw2 + 32'h8000) >> 16);
      bear16 = 16'((bang + 32'h8000) >> 16);
   end
   always_ff @(posedge clock) begin
      dprod_ff <= 60'(bmag[VW-2:0]) * 60'(InvGainQ30);
      err_b_ff <= bear16 - yaw16;
      fin_b_ff <= fin_d_ff[CL-1];
   end

   // stage C: round distance, magnitude of error
   logic [21:0] dist_c_ff;
   logic [15:0] err_c_ff;
   logic [15:0] aerr_c_ff;
   logic        fin_c_ff;
   always_ff @(posedge clock) begin
      dist_c_ff <= 22'((dprod_ff + (60'd1 << 37)) >> 38);
      err_c_ff  <= err_b_ff;
      aerr_c_ff <= err_b_ff[15] ? 16'(-err_b_ff) : err_b_ff;
      fin_c_ff  <= fin_b_ff;
   end

   logic [14:0] cos14;
   wps_cos u_cos (.clock(clock), .err(err_c_ff), .cos14(cos14));

   // hold side data for the cosine latency
   logic [21:0] dist_d_ff [CL];
   logic        neg_d_ff [CL];
   logic [27:0] amag_d_ff [CL];
   logic        fin_e_ff [CL];
   always_ff @(posedge clock) begin
      dist_d_ff[0] <= dist_c_ff;
      neg_d_ff[0]  <= err_c_ff[15];
      amag_d_ff[0] <= 28'(aerr_c_ff) * 28'(cfg_ff.turn_gain);
      fin_e_ff[0]  <= fin_c_ff;
      for (int i = 1; i < CL; i++) begin
         dist_d_ff[i] <= dist_d_ff[i-1];
         neg_d_ff[i]  <= neg_d_ff[i-1];
         amag_d_ff[i] <= amag_d_ff[i-1];
         fin_e_ff[i]  <= fin_e_ff[i-1];
      end
   end

   // stage F: speed limit, linear and angular products, advance flag
   logic [14:0] lim;
   logic [25:0] d14;
   logic [29:0] lprod_ff;
   logic [58:0] aprod_ff;
   logic        adv_f_ff, neg_f_ff;
   always_comb begin
      lim = (cfg_ff.max_linear_speed > 15'd16384) ? 15'd16384 : cfg_ff.max_linear_speed;
      d14 = {dist_d_ff[CL-1], 4'd0};
      if (d14 < 26'(lim)) lim = d14[14:0];
   end
   always_ff @(posedge clock) begin
      lprod_ff <= 30'(lim) * 30'(cos14) + 30'd8192;
      aprod_ff <= 59'(amag_d_ff[CL-1]) * 59'(PiQ29);
      neg_f_ff <= neg_d_ff[CL-1];
      adv_f_ff <= !fin_e_ff[CL-1] &&
                  (dist_d_ff[CL-1] < 22'(cfg_ff.reach_radius));
   end

   // stage G: round, clamp and register the word
   logic [20:0] ang;
   logic [15:0] angc;
   always_comb begin
      ang  = 21'((aprod_ff + (59'd1 << 37)) >> 38);
      angc = (ang > 21'(cfg_ff.max_angular_rate)) ? 16'(cfg_ff.max_angular_rate)
                                                   : ang[15:0];
   end
   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else       rsp_valid <= vld_ff[LAT-1];
      rsp_advance <= adv_f_ff;
      if (adv_f_ff) begin
         rsp_linear_velocity  <= '0;
         rsp_angular_velocity <= '0;
      end else begin
         rsp_linear_velocity  <= lprod_ff[28:14];
         rsp_angular_velocity <= neg_f_ff ? 16'(-angc) : angc;
      end
   end

endmodule
`default_nettype wire

// ===== tb/sv/wps_checker.sv =====
// ----------------------------------------------------------------------------
// wps_checker: result predictor and scoreboard for waypoint pursuit steering
// Watches accepted input words and register writes, computes the expected
// steering result for each word and compares every strobed result in order.
// ----------------------------------------------------------------------------
module wps_checker
   import wps_pkg::*;
(
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   input  wire               busy,
   input  wire signed [15:0] req_pose_x,
   input  wire signed [15:0] req_pose_y,
   input  wire signed [15:0] req_quat_w,
   input  wire signed [15:0] req_quat_z,
   input  wire signed [15:0] req_target_x,
   input  wire signed [15:0] req_target_y,
   input  wire               req_final_waypoint,
   input  wire               rsp_valid,
   input  wire               rsp_advance,
   input  wire [14:0]        rsp_linear_velocity,
   input  wire signed [15:0] rsp_angular_velocity,
   input  wire               csr_write,
   input  wire [1:0]         csr_index,
   input  wire [14:0]        csr_data,
   output int                fail_count,
   output int                pending
);

   typedef struct packed {
      logic              advance;
      logic [14:0]       linear;
      logic signed [15:0] angular;
   } steer_type;

   localparam longint InvGain = 652032874;
   localparam longint PiFix   = 1686629713;

   steer_type steer_q[$];
   cfg_type   cfg;
   int        mismatches;

   // floor shift for signed values
   function automatic longint asr(input longint v, input int s);
      return v >>> s;
   endfunction

   function automatic longint atan_step(input int i);
      longint t;
      t = atan_bam(i);
      return t;
   endfunction

   // vectoring: angle of (x,y) in 32-bit binary angle units, plus raw magnitude
   function automatic logic [31:0] vector_angle(input longint xi, input longint yi,
                                                output longint mag);
      longint x, y, xs, ys;
      logic [31:0] z;
      x = xi;
      y = yi;
      z = 32'd0;
      mag = 0;
      if (x == 0 && y == 0) return 32'd0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = 32'h8000_0000;
      end
      for (int i = 0; i < NumStages; i++) begin
         xs = asr(x, i);
         ys = asr(y, i);
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + atan_step(i);
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - atan_step(i);
         end
      end
      mag = x;
      return z;
   endfunction

   function automatic longint heading_cos(input longint a16);
      longint x, y, z, xs, ys;
      x = InvGain;
      y = 0;
      z = a16 * 65536;
      for (int i = 0; i < NumStages; i++) begin
         xs = asr(x, i);
         ys = asr(y, i);
         if (z >= 0) begin
            x = x - ys;
            y = y + xs;
            z = z - atan_step(i);
         end else begin
            x = x + ys;
            y = y - xs;
            z = z + atan_step(i);
         end
      end
      if (x <= 0) return 0;
      x = (x + 32768) >>> 16;
      return (x > 16384) ? 16384 : x;
   endfunction

   function automatic logic [15:0] to_bam16(input logic [31:0] a);
      logic [31:0] r;
      r = a + 32'h8000;
      return r[31:16];
   endfunction

   function automatic steer_type steer_predict(input longint px, input longint py,
         input longint qw, input longint qz, input longint tx, input longint ty,
         input logic fin);
      steer_type r;
      longint raw, unused, span, err, lim, c, lin, mag, ang, cap;
      logic [31:0] bearing, half_yaw;
      logic [15:0] yaw, diff;
      logic [63:0] prod;
      bearing = vector_angle((tx - px) * 256, (ty - py) * 256, raw);
      prod = raw * InvGain + (64'd1 << 37);
      span = prod >> 38;
      r = '0;
      if (!fin && span < longint'(cfg.reach_radius)) begin
         r.advance = 1'b1;
         return r;
      end
      half_yaw = vector_angle(qw * 256, qz * 256, unused);
      yaw = to_bam16(half_yaw * 2);
      diff = to_bam16(bearing) - yaw;
      err = longint'(signed'(diff));
      lim = cfg.max_linear_speed;
      if (lim > 16384) lim = 16384;
      if (span * 16 < lim) lim = span * 16;
      c = (err >= -16384 && err <= 16384) ? heading_cos(err) : 0;
      lin = (lim * c + 8192) >>> 14;
      mag = ((err < 0) ? -err : err) * longint'(cfg.turn_gain);
      prod = mag * PiFix + (64'd1 << 37);
      ang = prod >> 38;
      if (err < 0) ang = -ang;
      cap = cfg.max_angular_rate;
      if (ang > cap) ang = cap;
      if (ang < -cap) ang = -cap;
      r.linear = lin[14:0];
      r.angular = ang[15:0];
      return r;
   endfunction

   assign pending = steer_q.size();

   // track registers, queue predictions, compare results
   always @(posedge clock) begin
      steer_type e;
      if (reset) begin
         cfg.reach_radius       <= 13'd512;
         cfg.max_linear_speed   <= 15'd12288;
         cfg.turn_gain          <= 12'd512;
         cfg.max_angular_rate   <= 15'd16384;
         steer_q.delete();
         fail_count = 0;
         mismatches = 0;
      end else begin
         if (rsp_valid) begin
            if (steer_q.size() == 0) begin
               fail_count++;
               mismatches++;
               if (mismatches <= 10) $display("unexpected result word");
            end else begin
               e = steer_q.pop_front();
               if (e.advance !== rsp_advance || e.linear !== rsp_linear_velocity ||
                   e.angular !== rsp_angular_velocity) begin
                  fail_count++;
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp adv=%0d lin=%0d ang=%0d got adv=%0d lin=%0d ang=%0d",
                        e.advance, e.linear, e.angular, rsp_advance,
                        rsp_linear_velocity, rsp_angular_velocity);
               end
            end
         end
         if (start && !busy)
            steer_q = {steer_q, steer_predict(req_pose_x, req_pose_y, req_quat_w,
               req_quat_z, req_target_x, req_target_y, req_final_waypoint)};
         if (csr_write) begin
            case (csr_index)
               CSR_LOOKAHEAD: cfg.reach_radius       <= csr_data[12:0];
               CSR_MAX_LIN:   cfg.max_linear_speed   <= csr_data;
               CSR_TURN_GAIN: cfg.turn_gain          <= csr_data[11:0];
               CSR_MAX_ANG:   cfg.max_angular_rate   <= csr_data;
               default: ;
            endcase
         end
      end
   end

endmodule

// ===== tb/sv/tb_waypoint_pursuit_steering.sv =====
// ----------------------------------------------------------------------------
// tb_waypoint_pursuit_steering: testbench top for waypoint pursuit steering
// Drives directed and random pose words through several register settings;
// the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_waypoint_pursuit_steering;
   import wps_pkg::*;

   localparam int Latency  = 38;
   localparam int CycleCap = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [15:0] req_pose_x = '0, req_pose_y = '0, req_quat_w = '0;
   logic signed [15:0] req_quat_z = '0, req_target_x = '0, req_target_y = '0;
   logic req_final_waypoint = 1'b0;
   logic rsp_valid, rsp_advance;
   logic [14:0] rsp_linear_velocity;
   logic signed [15:0] rsp_angular_velocity;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = '0;
   logic [14:0] csr_data = '0;
   int fail_count, pending, cycles;
   int quiet_lo, quiet_hi, words;

   waypoint_pursuit_steering i_dut (.*);

   wps_checker i_checker (.*);

   initial forever #6 clock = ~clock;

   // watchdog
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CycleCap) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   task automatic csr_put(input logic [1:0] idx, input logic [14:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // wait until every expected word arrives, then let the pipe drain
   task automatic drain();
      @(posedge clock);
      start <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (Latency + 4) @(posedge clock);
   endtask

   // hold one word on the request ports until accepted
   task automatic send(input logic signed [15:0] px, py, qw, qz, tx, ty,
                       input logic fin, input bit may_idle);
      while (may_idle && $urandom_range(0, 99) < 13) begin
         @(posedge clock);
         start <= 1'b0;
      end
      @(posedge clock);
      while (busy) @(posedge clock);
      start <= 1'b1;
      req_pose_x <= px; req_pose_y <= py;
      req_quat_w <= qw; req_quat_z <= qz;
      req_target_x <= tx; req_target_y <= ty;
      req_final_waypoint <= fin;
      words++;
   endtask

   function automatic logic signed [15:0] quat_part();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'sd16384;
      if (r == 1) return -16'sd16384;
      if (r == 2) return 16'sd0;
      return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
   endfunction

   task automatic random_word(input bit may_idle);
      logic signed [15:0] px, py, tx, ty;
      int mode;
      px = 16'($urandom);
      py = 16'($urandom);
      mode = $urandom_range(0, 3);
      // near targets exercise advance, far ones exercise steering
      if (mode == 0) begin
         tx = px + $signed(16'($urandom_range(0, 2047)) - 16'sd1024);
         ty = py + $signed(16'($urandom_range(0, 2047)) - 16'sd1024);
      end else if (mode == 1) begin
         tx = px + $signed(16'($urandom_range(0, 16383)) - 16'sd8192);
         ty = py + $signed(16'($urandom_range(0, 16383)) - 16'sd8192);
      end else begin
         tx = 16'($urandom);
         ty = 16'($urandom);
      end
      send(px, py, quat_part(), quat_part(), tx, ty, 1'($urandom_range(0, 1)), may_idle);
   endtask

   initial begin
      words = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, zero vectors, error of -pi
      send(16'sh7fff, 16'sh7fff, 16'sd16384, 16'sd0, -16'sh8000, -16'sh8000, 1'b0, 0);
      send(-16'sh8000, -16'sh8000, 16'sd16384, 16'sd0, 16'sh7fff, 16'sh7fff, 1'b1, 0);
      send(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 0);
      send(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 0);
      send(16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd4000, 16'sd0, 1'b0, 0);
      send(16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd4000, 16'sd0, 1'b1, 0);
      send(16'sd0, 16'sd0, -16'sd16384, 16'sd0, -16'sd4000, 16'sd0, 1'b0, 0);
      send(16'sd0, 16'sd0, 16'sd11585, 16'sd11585, 16'sd0, 16'sd9000, 1'b1, 0);
      send(16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, -16'sd9000, 1'b0, 0);
      send(16'sd100, 16'sd100, 16'sd16384, 16'sd0, 16'sd611, 16'sd100, 1'b0, 0);
      send(16'sd100, 16'sd100, 16'sd16384, 16'sd0, 16'sd612, 16'sd100, 1'b0, 0);
      send(16'sd0, 16'sd0, 16'sd16384, 16'sd0, -16'sd30000, -16'sd1, 1'b1, 0);
      drain();

      // sweep register settings, extremes included
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               csr_put(CSR_LOOKAHEAD, 15'd0);   csr_put(CSR_MAX_LIN, 15'd16384);
               csr_put(CSR_TURN_GAIN, 15'd4095); csr_put(CSR_MAX_ANG, 15'd32767);
            end
            1: begin
               csr_put(CSR_LOOKAHEAD, 15'd8191); csr_put(CSR_MAX_LIN, 15'd32767);
               csr_put(CSR_TURN_GAIN, 15'd0);    csr_put(CSR_MAX_ANG, 15'd0);
            end
            2: begin
               csr_put(CSR_LOOKAHEAD, 15'd512);  csr_put(CSR_MAX_LIN, 15'd0);
               csr_put(CSR_TURN_GAIN, 15'd256);  csr_put(CSR_MAX_ANG, 15'd16384);
            end
            default: begin
               csr_put(CSR_LOOKAHEAD, 15'($urandom_range(0, 8191)));
               csr_put(CSR_MAX_LIN, 15'($urandom_range(0, 16384)));
               csr_put(CSR_TURN_GAIN, 15'($urandom_range(0, 4095)));
               csr_put(CSR_MAX_ANG, 15'($urandom));
            end
         endcase
         // no idling inside a stretch of each phase
         quiet_lo = $urandom_range(20, 100);
         quiet_hi = quiet_lo + 60;
         for (int n = 0; n < 205; n++) begin
            random_word(!(n >= quiet_lo && n < quiet_hi));
            // pause until everything arrives mid-phase
            if (n == 150) drain();
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/wps_pkg.sv
rtl/core/wps_vector.sv
rtl/core/wps_cos.sv
rtl/core/waypoint_pursuit_steering.sv
tb/sv/wps_checker.sv
tb/sv/tb_waypoint_pursuit_steering.sv
